>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define MM_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked at every rising edge outside reset.
`define MM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/mm_pkg.sv
// Package for the modular multiplier: widths, stage counts and the
// record that travels down the reduction pipeline. Depends on nothing.
`default_nettype none

package mm_pkg;

  localparam int OPERAND_WIDTH  = 31;
  localparam int PROD_WIDTH     = 2 * OPERAND_WIDTH;
  localparam int BITS_PER_STAGE = 2;
  localparam int NUM_STAGES     = PROD_WIDTH / BITS_PER_STAGE;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [PROD_WIDTH-1:0]    product_t;

  // Payload of one item inside the pipeline. The product shifts left as
  // its bits are consumed; rem holds the partial remainder so far.
  typedef struct packed {
    product_t prod;
    operand_t rem;
    operand_t modulus;
    logic     zero_mod;
  } mm_data_t;

endpackage

`default_nettype wire

>>> rtl/mm_mult.sv
// First pipeline stage: forms the full double-width product and starts
// the reduction record. Depends on mm_pkg.
`default_nettype none

module mm_mult import mm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire logic     in_valid,
  input  wire operand_t multiplicand,
  input  wire operand_t multiplier,
  input  wire operand_t modulus,
  output logic          out_valid,
  output mm_data_t      out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.prod     <= product_t'(multiplicand) * product_t'(multiplier);
      out_data.rem      <= '0;
      out_data.modulus  <= modulus;
      out_data.zero_mod <= (modulus == '0);
    end
  end

endmodule

`default_nettype wire

>>> rtl/mm_reduce_stage.sv
// One stage of the restoring remainder pipeline: shifts BITS_PER_STAGE
// product bits into the partial remainder, subtracting the modulus when
// it fits. Depends on mm_pkg.
`default_nettype none

module mm_reduce_stage import mm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire logic     in_valid,
  input  wire mm_data_t in_data,
  output logic          out_valid,
  output mm_data_t      out_data
);

  mm_data_t data_next;

  always_comb begin
    logic [OPERAND_WIDTH:0] trial;
    data_next = in_data;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      trial = {data_next.rem, data_next.prod[PROD_WIDTH-1]};
      if (trial >= {1'b0, data_next.modulus}) begin
        trial = trial - {1'b0, data_next.modulus};
      end
      data_next.rem  = trial[OPERAND_WIDTH-1:0];
      data_next.prod = {data_next.prod[PROD_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mm_out_buf.sv
// Output register with a one-entry skid stage, so the pipeline moves on a
// registered condition rather than on the downstream ready. Depends on mm_pkg.
`default_nettype none

module mm_out_buf import mm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire mm_data_t push_data,
  output logic          skid_full,
  output logic          out_valid,
  input  wire logic     out_ready,
  output operand_t      remainder,
  output logic          zero_modulus
);

  operand_t skid_rem;
  logic     skid_zero;
  operand_t push_rem;

  // A zero modulus leaves garbage in the partial remainder; force it to zero.
  assign push_rem = push_data.zero_mod ? '0 : push_data.rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_ready) begin
        remainder    <= skid_rem;
        zero_modulus <= skid_zero;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_rem  <= push_rem;
        skid_zero <= push_data.zero_mod;
      end else begin
        remainder    <= push_rem;
        zero_modulus <= push_data.zero_mod;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/modular_multiplier.sv
// Top level of the pipelined modular multiplier: (a * b) mod n, exact.
// Depends on mm_pkg, mm_mult, mm_reduce_stage, mm_out_buf, assert_macros.svh.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ------------------------------------------
//   input    in_valid / in_ready   multiplicand, multiplier, modulus (31 b)
//   output   out_valid / out_ready remainder (31 b), zero_modulus (1 b)
//
// One item enters every cycle while in_ready is high. On its way to out_valid
// each item passes the multiplier stage, one restoring-remainder stage per two
// product bits, and the output register.
// Reset (rst, synchronous) clears every valid bit and the skid stage.
// When the output is stalled the skid stage catches one more result; only
// then does in_ready drop, and the whole pipeline holds until it drains.
`default_nettype none
`include "assert_macros.svh"

module modular_multiplier import mm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire operand_t multiplicand,
  input  wire operand_t multiplier,
  input  wire operand_t modulus,
  output logic          out_valid,
  input  wire logic     out_ready,
  output operand_t      remainder,
  output logic          zero_modulus
);

  // The pipeline advances as a whole whenever the skid stage is empty. That
  // condition is a register, so no long ready chain runs across the stages.
  logic     advance;
  logic     skid_full;
  logic     stage_valid [NUM_STAGES+1];
  mm_data_t stage_data  [NUM_STAGES+1];

  assign advance  = !skid_full;
  assign in_ready = advance;

  // Stage 0: the full 62-bit product.
  mm_mult u_mult (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (in_valid),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .modulus      (modulus),
    .out_valid    (stage_valid[0]),
    .out_data     (stage_data[0])
  );

  // Reduction: each stage folds two product bits into the partial
  // remainder, keeping it below a nonzero modulus throughout.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_reduce
    mm_reduce_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (stage_valid[s]),
      .in_data   (stage_data[s]),
      .out_valid (stage_valid[s+1]),
      .out_data  (stage_data[s+1])
    );
  end

  // Output register plus skid entry; results in the last stage transfer in
  // whenever the pipeline advances.
  mm_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (stage_valid[NUM_STAGES] && advance),
    .push_data    (stage_data[NUM_STAGES]),
    .skid_full    (skid_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .remainder    (remainder),
    .zero_modulus (zero_modulus)
  );

  // A flagged result always carries a zero remainder.
  `MM_ASSERT_IMPLIES(a_zero_mod_rem, clk, rst, out_valid && zero_modulus,
                     remainder == '0, "zero modulus with nonzero remainder")

  // The skid entry is only ever occupied behind a valid output register.
  `MM_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_full, out_valid,
                     "skid full while output empty")

  // The skid entry fills only when the output register held a result that was not taken.
  `MM_ASSERT_IMPLIES(a_skid_on_stall, clk, rst, $rose(skid_full),
                     $past(out_valid && !out_ready), "skid filled without an output stall")

endmodule

`default_nettype wire

>>> tb/modular_multiplier_test.sv
// Self-checking testbench for modular_multiplier: directed corner operands, then
// random bursts under input gaps and output stalls, each result checked in order.
// Depends on mm_pkg and the modular_multiplier RTL.
`default_nettype none

module modular_multiplier_test;
  import mm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam operand_t OPND_MAX     = '1;
  localparam int       RANDOM_ITEMS = 750;
  // Margin kept after every result has come back.
  localparam int       SETTLE_CYCLES = 50;
  // Output stall long enough to fill the pipeline and its skid stage.
  localparam int       LONG_HOLD_CYCLES = 300;

  // Scoreboard: predicts (a * b) mod n for every accepted operand set and
  // compares the results in arrival order.
  class product_scoreboard;
    typedef struct {
      operand_t remainder;
      logic     zero_flag;
    } residue_t;

    residue_t residue_q[$];
    int       mismatches;
    int       unexpected;
    int       checked;
    int       zero_mod_items;

    // Exact remainder of the full 62-bit product.
    function residue_t compute_residue(operand_t a, operand_t b, operand_t n);
      residue_t         r;
      bit [PROD_WIDTH-1:0] full_prod;
      bit [PROD_WIDTH-1:0] reduced;
      full_prod = {{OPERAND_WIDTH{1'b0}}, a} * {{OPERAND_WIDTH{1'b0}}, b};
      if (n == '0) begin
        r.remainder = '0;
        r.zero_flag = 1'b1;
      end else begin
        reduced     = full_prod % {{OPERAND_WIDTH{1'b0}}, n};
        r.remainder = reduced[OPERAND_WIDTH-1:0];
        r.zero_flag = 1'b0;
      end
      return r;
    endfunction

    function void note_operands(operand_t a, operand_t b, operand_t n);
      if (n == '0) zero_mod_items++;
      residue_q.push_back(compute_residue(a, b, n));
    endfunction

    function void check_result(operand_t rem, logic zf);
      residue_t want;
      checked++;
      if (residue_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: result rem=%h flag=%b arrived with nothing outstanding", rem, zf);
        return;
      end
      want = residue_q.pop_front();
      if (rem !== want.remainder || zf !== want.zero_flag) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: result %0d: remainder exp %h got %h, zero_modulus exp %b got %b",
                   checked, want.remainder, rem, want.zero_flag, zf);
      end
    endfunction

    function int pending();
      return residue_q.size();
    endfunction

    function int failures();
      return mismatches + unexpected + residue_q.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  operand_t multiplicand = '0;
  operand_t multiplier = '0;
  operand_t modulus = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  operand_t remainder;
  logic     zero_modulus;

  product_scoreboard sb = new();

  int items_sent = 0;
  int input_stall_cycles = 0;
  // Written by the stimulus process, taken over and counted down by the
  // receiver process.
  int hold_request = 0;

  modular_multiplier u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .modulus      (modulus),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .remainder    (remainder),
    .zero_modulus (zero_modulus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Safety net: far beyond the slowest correct run, even with the long
  // output stall.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Present one operand set at the falling edge and hold it until the
  // transfer happens. Valid stays high afterward, so a following call
  // makes a back-to-back transfer.
  task automatic send_item(operand_t a, operand_t b, operand_t n);
    @(negedge clk);
    in_valid     <= 1'b1;
    multiplicand <= a;
    multiplier   <= b;
    modulus      <= n;
    do @(posedge clk); while (!in_ready);
    sb.note_operands(a, b, n);
    items_sent++;
  endtask

  // Drop valid for a number of cycles. The payload is scrambled meanwhile,
  // since the block must ignore it while valid is low.
  task automatic sender_gap(int cycles);
    @(negedge clk);
    in_valid     <= 1'b0;
    multiplicand <= operand_t'($urandom);
    multiplier   <= operand_t'($urandom);
    modulus      <= operand_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering items until every outstanding result has come back.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Factors favor the edges and values below the modulus, but half are
  // plain random so every bit toggles.
  function automatic operand_t pick_factor(operand_t n);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return OPND_MAX;
      2:       return OPND_MAX - operand_t'($urandom_range(0, 3));
      3, 4:    return (n != '0) ? operand_t'($urandom % n) : operand_t'($urandom);
      default: return operand_t'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    operand_t n;
    case ($urandom_range(0, 19))
      0:       n = '0;
      1, 2:    n = operand_t'($urandom_range(1, 255));
      3:       n = OPND_MAX - operand_t'($urandom_range(0, 15));
      4:       n = operand_t'(1) << $urandom_range(0, OPERAND_WIDTH - 1);
      default: n = operand_t'($urandom);
    endcase
    send_item(pick_factor(n), pick_factor(n), n);
  endtask

  // Receiver: cycles through its own stall modes, including stretches of
  // constant readiness, and serves a long hold-off when one is requested.
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          2: out_ready <= (mode_left % 5 < 3);
          default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Results are taken at the rising edge; out_ready only moves at the
  // falling edge, so the transfer condition is stable here.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(remainder, zero_modulus);
      if (in_valid && !in_ready) input_stall_cycles++;
    end
  end

  initial begin
    int burst;
    int gap;
    bit hold_done;
    bit drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed corners, sent back to back: zero modulus with small and
    // full-scale factors, modulus of one, the largest remainder, factors
    // above the modulus and powers of two.
    send_item('0, '0, '0);
    send_item(OPND_MAX, OPND_MAX, '0);
    send_item(31'd3, OPND_MAX, '0);
    send_item(OPND_MAX, OPND_MAX, OPND_MAX);
    send_item(OPND_MAX, OPND_MAX, OPND_MAX - 31'd1);
    send_item(OPND_MAX, OPND_MAX, 31'd1);
    send_item(OPND_MAX, OPND_MAX, 31'd2);
    send_item('0, OPND_MAX, OPND_MAX - 31'd1);
    send_item(OPND_MAX, '0, 31'd12345);
    send_item(31'd1, 31'd1, OPND_MAX);
    send_item(31'd1, OPND_MAX - 31'd1, OPND_MAX);
    send_item(OPND_MAX - 31'd1, OPND_MAX - 31'd1, OPND_MAX);
    send_item(31'h4000_0000, 31'h4000_0000, 31'h4000_0001);
    send_item(31'h4000_0000, 31'd2, 31'h4000_0000);
    send_item(OPND_MAX, 31'd1, 31'h4000_0000);
    send_item(31'd12, 31'd5, 31'd7);
    send_item(31'd6, 31'd5, 31'd7);
    send_item(31'd100, 31'd200, 31'd3);
    send_item(31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFF1);
    send_item(31'h2AAA_AAAA, 31'h5555_5555, 31'h0000_FFFF);
    wait_until_drained();

    // Random bursts. Partway in, the receiver holds off for a long stretch
    // while a long burst keeps coming, so the pipeline fills and in_ready
    // drops. Later the sender waits once for the pipeline to empty.
    while (items_sent < RANDOM_ITEMS + 20) begin
      if (!hold_done && items_sent >= 270) begin
        hold_request = LONG_HOLD_CYCLES;
        hold_done    = 1'b1;
        burst        = 80;
      end else begin
        burst = $urandom_range(1, 40);
      end
      repeat (burst) send_random_item();
      if (!drain_done && items_sent >= 520) begin
        wait_until_drained();
        drain_done = 1'b1;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) sender_gap(gap);
      end
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d operand sets (%0d with zero modulus), %0d results checked.",
             items_sent, sb.zero_mod_items, sb.checked);
    $display("Input was held off for %0d cycles; %0d mismatches, %0d stray results.",
             input_stall_cycles, sb.mismatches, sb.unexpected);
    if (sb.failures() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/mm_pkg.sv
rtl/mm_mult.sv
rtl/mm_reduce_stage.sv
rtl/mm_out_buf.sv
rtl/modular_multiplier.sv
tb/modular_multiplier_test.sv
